FILE: hw/rtl/triangle_tangent_bitangent_macros.svh
// Assertion macros for the tangent/bitangent block.
`ifndef TRIANGLE_TANGENT_BITANGENT_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_MACROS_SVH
// Check that an antecedent implies a consequent in the same cycle.
`define TTB_ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("implication failed");
// Check that an antecedent implies a consequent in the next cycle.
`define TTB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("next-cycle check failed");
`endif

FILE: hw/rtl/ttb_pkg.sv
// Package: types, constants and state codes for the tangent/bitangent block.
package ttb_pkg;
    localparam int POS_WIDTH_DEF = 16;
    localparam int UV_WIDTH_DEF  = 16;
    localparam int OUT_WIDTH_DEF = 32;
    localparam int POS_FRAC      = 8;
    localparam int UV_FRAC       = 12;
    localparam int OUT_FRAC      = 16;
    localparam int QSHIFT        = OUT_FRAC + UV_FRAC - POS_FRAC;

    typedef struct packed {
        logic signed [POS_WIDTH_DEF-1:0] pos_x;
        logic signed [POS_WIDTH_DEF-1:0] pos_y;
        logic signed [POS_WIDTH_DEF-1:0] pos_z;
        logic signed [UV_WIDTH_DEF-1:0]  tex_u;
        logic signed [UV_WIDTH_DEF-1:0]  tex_v;
    } vertex_t;

    typedef struct packed {
        logic signed [OUT_WIDTH_DEF-1:0] tangent_x;
        logic signed [OUT_WIDTH_DEF-1:0] tangent_y;
        logic signed [OUT_WIDTH_DEF-1:0] tangent_z;
        logic signed [OUT_WIDTH_DEF-1:0] bitangent_x;
        logic signed [OUT_WIDTH_DEF-1:0] bitangent_y;
        logic signed [OUT_WIDTH_DEF-1:0] bitangent_z;
        logic                            degenerate;
    } basis_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DET,
        ST_NUM,
        ST_DIV,
        ST_OUT
    } state_t;
endpackage

FILE: hw/rtl/ttb_serial_mul.sv
// Bit-serial signed multiplier: one multiplier bit per cycle.
module ttb_serial_mul #(
    parameter int AW = 18,
    parameter int BW = 18
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic                    busy,
    output logic signed [AW+BW-1:0] prod
);
    localparam int CW = $clog2(BW + 1);
    logic [CW-1:0]           cnt_reg, cnt_next;
    logic [BW-1:0]           mb_reg, mb_next;
    logic signed [AW+BW-1:0] acc_reg, acc_next;
    logic signed [AW+BW-1:0] ma_reg, ma_next;
    logic                    busy_reg, busy_next;

    always_comb
    begin
        cnt_next  = cnt_reg;
        mb_next   = mb_reg;
        acc_next  = acc_reg;
        ma_next   = ma_reg;
        busy_next = busy_reg;
        if (start)
        begin
            cnt_next  = CW'(BW);
            mb_next   = b;
            acc_next  = '0;
            ma_next   = (AW+BW)'(a);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // top bit of b has negative weight
            if (mb_reg[0])
            begin
                if (cnt_reg == CW'(1))
                    acc_next = acc_reg - ma_reg;
                else
                    acc_next = acc_reg + ma_reg;
            end
            ma_next  = ma_reg <<< 1;
            mb_next  = mb_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mb_reg  <= mb_next;
        acc_reg <= acc_next;
        ma_reg  <= ma_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;
endmodule

FILE: hw/rtl/ttb_serial_div.sv
// Bit-serial restoring divider with round-half-away and saturation.
module ttb_serial_div #(
    parameter int NW = 40,
    parameter int DW = 36,
    parameter int OW = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic signed [DW-1:0] den,
    output logic                 busy,
    output logic signed [OW-1:0] quot
);
    // dividend = 2|num|*2^QSHIFT + |den|, divisor = 2|den|
    localparam int SH  = ttb_pkg::QSHIFT;
    localparam int XW  = NW + SH + 2;
    localparam int RW  = DW + 2;
    localparam int CW  = $clog2(XW + 1);

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [XW-1:0] x_reg, x_next;
    logic [RW-1:0] r_reg, r_next;
    logic [RW-1:0] d_reg, d_next;
    logic [XW-1:0] q_reg, q_next;
    logic          neg_reg, neg_next;
    logic          busy_reg, busy_next;

    logic [NW-1:0] an;
    logic [DW-1:0] ad;
    logic [RW-1:0] rs;
    logic [RW:0]   diff;
    logic          q_ovf;

    always_comb
    begin
        an = num[NW-1] ? NW'(-num) : NW'(num);
        ad = den[DW-1] ? DW'(-den) : DW'(den);
        rs = {r_reg[RW-2:0], x_reg[XW-1]};
        diff = {1'b0, rs} - {1'b0, d_reg};
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        if (start)
        begin
            x_next    = (XW'(an) << (SH + 1)) + XW'(ad);
            d_next    = RW'(ad) << 1;
            r_next    = '0;
            q_next    = '0;
            neg_next  = num[NW-1] ^ den[DW-1];
            cnt_next  = CW'(XW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = x_reg << 1;
            if (!diff[RW])
            begin
                r_next = diff[RW-1:0];
                q_next = {q_reg[XW-2:0], 1'b1};
            end
            else
            begin
                r_next = rs;
                q_next = {q_reg[XW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_comb
    begin
        q_ovf = |q_reg[XW-1:OW-1];
        if (neg_reg && (q_reg != '0))
        begin
            // a magnitude of 2^(OW-1) or more clips to the most negative value
            if (q_ovf)
                quot = {1'b1, {(OW-1){1'b0}}};
            else
                quot = OW'(-q_reg[OW-1:0]);
        end
        else if (q_ovf)
            quot = {1'b0, {(OW-1){1'b1}}};
        else
            quot = OW'(q_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign busy = busy_reg;
endmodule

FILE: hw/rtl/triangle_tangent_bitangent.sv
// Top level: tangent and bitangent per triangle from position and UV deltas.
// Usage:
//  - in (vertex_t) with in_valid/in_ready: one triangle-list vertex per item.
//  - out (basis_t) with out_valid/out_ready: one result item per triangle,
//    issued after the third vertex; it applies to all three vertices.
//  - Vertices 0 and 1 are held. The third vertex starts a sequence on
//    one bit-serial multiplier and one bit-serial divider: 2 products for
//    the determinant, 12 for the numerators (each: start, 17 bit steps,
//    handoff), then 6 quotients (each: start, 57 bit steps, handoff).
//    Degenerate triangles skip numerators and divisions; their result has
//    zeros and degenerate set.
//  - One triangle is worked on at a time; in_ready is low from the third
//    vertex until the result moves into the output register.
//  - When the receiver stalls, the result holds in the output register and
//    the next triangle is still taken in and computed; it then waits, with
//    in_ready low, until the output register frees.
//  - Reset clears the vertex slot and handshake state; held vertices are
//    undefined until written, and no read of them happens before that.
module triangle_tangent_bitangent (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  ttb_pkg::vertex_t in,
    output logic            out_valid,
    input  logic            out_ready,
    output ttb_pkg::basis_t  out
);
    `include "triangle_tangent_bitangent_macros.svh"

    localparam int PW = ttb_pkg::POS_WIDTH_DEF;
    localparam int UW = ttb_pkg::UV_WIDTH_DEF;
    localparam int OW = ttb_pkg::OUT_WIDTH_DEF;
    localparam int DEW = PW + 1;        // edge width
    localparam int DUW = UW + 1;        // uv delta width
    localparam int PRW = DEW + DUW;     // product width
    localparam int NMW = PRW + 1;       // numerator / determinant width

    ttb_pkg::state_t state_reg, state_next;
    logic [1:0]  slot_reg, slot_next;
    logic [4:0]  idx_reg, idx_next;   // product or quotient index
    logic        phase_reg, phase_next; // 0: start unit, 1: wait

    logic signed [PW-1:0] p0_reg [3];
    logic signed [PW-1:0] p1_reg [3];
    logic signed [UW-1:0] t0_reg [2];
    logic signed [UW-1:0] t1_reg [2];
    logic signed [DEW-1:0] e1_reg [3];
    logic signed [DEW-1:0] e2_reg [3];
    logic signed [DUW-1:0] du1_reg, dv1_reg, du2_reg, dv2_reg;
    logic signed [NMW-1:0] det_reg, det_next;
    logic signed [NMW-1:0] num_reg [6];
    logic signed [OW-1:0]  res_reg [6];
    logic                  deg_reg;
    logic                  out_valid_reg;
    ttb_pkg::basis_t       out_reg, out_next;
    logic                  out_load;

    logic                  mul_start, mul_busy;
    logic                  div_start, div_busy;
    logic signed [DEW-1:0] mul_a;
    logic signed [DUW-1:0] mul_b;
    logic signed [PRW-1:0] mul_p;
    logic signed [NMW-1:0] div_n;
    logic signed [OW-1:0]  div_q;
    logic                  acc_in;
    logic [2:0]            comp;

    assign in_ready  = (state_reg == ttb_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out       = out_reg;
    assign acc_in    = in_valid && in_ready;
    assign comp      = 3'(idx_reg >> 1);
    // finished result moves out once the output register is free
    assign out_load  = (state_reg == ttb_pkg::ST_OUT) && (!out_valid_reg || out_ready);

    // Operand selection: products 0,1 form det; then per component k
    // tangent num = dv2*e1 - dv1*e2, bitangent num = du1*e2 - du2*e1.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ttb_pkg::ST_DET)
        begin
            mul_a = DEW'(du1_reg);
            mul_b = idx_reg[0] ? du2_reg : dv2_reg;
            if (idx_reg[0])
                mul_a = DEW'(dv1_reg);
        end
        else
        begin
            // idx: comp*2 + term, comp 0..5 (0..2 tangent, 3..5 bitangent)
            if (comp < 3'd3)
            begin
                mul_a = idx_reg[0] ? e2_reg[comp[1:0]] : e1_reg[comp[1:0]];
                mul_b = idx_reg[0] ? dv1_reg : dv2_reg;
            end
            else
            begin
                mul_a = idx_reg[0] ? e1_reg[2'(comp - 3'd3)] : e2_reg[2'(comp - 3'd3)];
                mul_b = idx_reg[0] ? du2_reg : du1_reg;
            end
        end
        div_n = num_reg[idx_reg[2:0]];
    end

    ttb_serial_mul #(.AW(DEW), .BW(DUW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_p)
    );

    ttb_serial_div #(.NW(NMW), .DW(NMW), .OW(OW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (det_reg),
        .busy  (div_busy),
        .quot  (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        det_next   = det_reg;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            ttb_pkg::ST_IDLE:
            begin
                if (acc_in)
                begin
                    if (slot_reg == 2'd0)
                        slot_next = 2'd1;
                    else if (slot_reg == 2'd1)
                        slot_next = 2'd2;
                    else
                    begin
                        slot_next  = 2'd0;
                        state_next = ttb_pkg::ST_DET;
                        idx_next   = '0;
                        phase_next = 1'b0;
                    end
                end
            end
            ttb_pkg::ST_DET:
            begin
                if (!phase_reg)
                begin
                    mul_start  = 1'b1;
                    phase_next = 1'b1;
                end
                else if (!mul_busy)
                begin
                    phase_next = 1'b0;
                    if (idx_reg[0])
                    begin
                        det_next = det_reg - NMW'(mul_p);
                        idx_next = '0;
                        if (det_next == '0)
                            state_next = ttb_pkg::ST_OUT;
                        else
                            state_next = ttb_pkg::ST_NUM;
                    end
                    else
                    begin
                        det_next = NMW'(mul_p);
                        idx_next = 5'd1;
                    end
                end
            end
            ttb_pkg::ST_NUM:
            begin
                if (!phase_reg)
                begin
                    mul_start  = 1'b1;
                    phase_next = 1'b1;
                end
                else if (!mul_busy)
                begin
                    phase_next = 1'b0;
                    if (idx_reg == 5'd11)
                    begin
                        idx_next   = '0;
                        state_next = ttb_pkg::ST_DIV;
                    end
                    else
                        idx_next = idx_reg + 5'd1;
                end
            end
            ttb_pkg::ST_DIV:
            begin
                if (!phase_reg)
                begin
                    div_start  = 1'b1;
                    phase_next = 1'b1;
                end
                else if (!div_busy)
                begin
                    phase_next = 1'b0;
                    if (idx_reg == 5'd5)
                        state_next = ttb_pkg::ST_OUT;
                    else
                        idx_next = idx_reg + 5'd1;
                end
            end
            ttb_pkg::ST_OUT:
            begin
                if (out_load)
                    state_next = ttb_pkg::ST_IDLE;
            end
            default:
                state_next = ttb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttb_pkg::ST_IDLE;
            slot_reg      <= '0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
        if (acc_in && slot_reg == 2'd0)
        begin
            p0_reg[0] <= in.pos_x;
            p0_reg[1] <= in.pos_y;
            p0_reg[2] <= in.pos_z;
            t0_reg[0] <= in.tex_u;
            t0_reg[1] <= in.tex_v;
        end
        if (acc_in && slot_reg == 2'd1)
        begin
            p1_reg[0] <= in.pos_x;
            p1_reg[1] <= in.pos_y;
            p1_reg[2] <= in.pos_z;
            t1_reg[0] <= in.tex_u;
            t1_reg[1] <= in.tex_v;
        end
        if (acc_in && slot_reg[1])
        begin
            e1_reg[0] <= DEW'(p1_reg[0]) - DEW'(p0_reg[0]);
            e1_reg[1] <= DEW'(p1_reg[1]) - DEW'(p0_reg[1]);
            e1_reg[2] <= DEW'(p1_reg[2]) - DEW'(p0_reg[2]);
            e2_reg[0] <= DEW'(in.pos_x) - DEW'(p0_reg[0]);
            e2_reg[1] <= DEW'(in.pos_y) - DEW'(p0_reg[1]);
            e2_reg[2] <= DEW'(in.pos_z) - DEW'(p0_reg[2]);
            du1_reg   <= DUW'(t1_reg[0]) - DUW'(t0_reg[0]);
            dv1_reg   <= DUW'(t1_reg[1]) - DUW'(t0_reg[1]);
            du2_reg   <= DUW'(in.tex_u) - DUW'(t0_reg[0]);
            dv2_reg   <= DUW'(in.tex_v) - DUW'(t0_reg[1]);
        end
        if (state_reg == ttb_pkg::ST_NUM && phase_reg && !mul_busy)
        begin
            if (!idx_reg[0])
                num_reg[comp] <= NMW'(mul_p);
            else
                num_reg[comp] <= num_reg[comp] - NMW'(mul_p);
        end
        if (state_reg == ttb_pkg::ST_DIV && phase_reg && !div_busy)
            res_reg[idx_reg[2:0]] <= div_q;
        if (state_reg == ttb_pkg::ST_DET)
            deg_reg <= (det_next == '0);
        if (out_load)
            out_reg <= out_next;
    end

    always_comb
    begin
        out_next.degenerate  = deg_reg;
        out_next.tangent_x   = deg_reg ? '0 : res_reg[0];
        out_next.tangent_y   = deg_reg ? '0 : res_reg[1];
        out_next.tangent_z   = deg_reg ? '0 : res_reg[2];
        out_next.bitangent_x = deg_reg ? '0 : res_reg[3];
        out_next.bitangent_y = deg_reg ? '0 : res_reg[4];
        out_next.bitangent_z = deg_reg ? '0 : res_reg[5];
    end

    `TTB_ASSERT_IMPLY(a_busy_no_in, clk, rst_n, state_reg != ttb_pkg::ST_IDLE, !in_ready)
    `TTB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out))
    `TTB_ASSERT_NEXT(a_third_starts, clk, rst_n, acc_in && slot_reg == 2'd2, state_reg == ttb_pkg::ST_DET)
endmodule

FILE: sim/triangle_tangent_bitangent_checker.sv
// Checker: watches both channels, predicts each triangle's basis and compares.
module triangle_tangent_bitangent_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  ttb_pkg::vertex_t in,
    input  logic             out_valid,
    input  logic             out_ready,
    input  ttb_pkg::basis_t  out,
    output int               errors,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    ttb_pkg::basis_t  basis_q[$];
    int               corner;
    ttb_pkg::vertex_t held[2];

    // (num * 2^QSHIFT) / den, half away from zero, saturated to 32 bits
    function automatic logic signed [31:0] scaled_quot(longint num, longint den);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        bit           neg;
        neg = (num < 0) != (den < 0);
        an  = 128'(num < 0 ? -num : num);
        ad  = 128'(den < 0 ? -den : den);
        q   = ((an << (ttb_pkg::QSHIFT + 1)) + ad) / (ad << 1);
        if (q == 0)
            neg = 0;
        if (neg)
            return (q > 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > 128'h7fff_ffff) ? 32'sh7fff_ffff : $signed(q[31:0]);
    endfunction

    function automatic ttb_pkg::basis_t triangle_basis(ttb_pkg::vertex_t v0,
                                                       ttb_pkg::vertex_t v1,
                                                       ttb_pkg::vertex_t v2);
        ttb_pkg::basis_t r;
        longint e1[3];
        longint e2[3];
        longint du1, dv1, du2, dv2, det;
        longint tn[3];
        longint bn[3];
        e1[0] = longint'(v1.pos_x) - v0.pos_x;
        e1[1] = longint'(v1.pos_y) - v0.pos_y;
        e1[2] = longint'(v1.pos_z) - v0.pos_z;
        e2[0] = longint'(v2.pos_x) - v0.pos_x;
        e2[1] = longint'(v2.pos_y) - v0.pos_y;
        e2[2] = longint'(v2.pos_z) - v0.pos_z;
        du1 = longint'(v1.tex_u) - v0.tex_u;
        dv1 = longint'(v1.tex_v) - v0.tex_v;
        du2 = longint'(v2.tex_u) - v0.tex_u;
        dv2 = longint'(v2.tex_v) - v0.tex_v;
        det = du1 * dv2 - du2 * dv1;
        r = '0;
        if (det == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        for (int k = 0; k < 3; k++)
        begin
            tn[k] = dv2 * e1[k] - dv1 * e2[k];
            bn[k] = du1 * e2[k] - du2 * e1[k];
        end
        r.tangent_x   = scaled_quot(tn[0], det);
        r.tangent_y   = scaled_quot(tn[1], det);
        r.tangent_z   = scaled_quot(tn[2], det);
        r.bitangent_x = scaled_quot(bn[0], det);
        r.bitangent_y = scaled_quot(bn[1], det);
        r.bitangent_z = scaled_quot(bn[2], det);
        return r;
    endfunction

    assign pending = basis_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner = 0;
            errors = 0;
            basis_q.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                if (corner < 2)
                begin
                    held[corner] = in;
                    corner++;
                end
                else
                begin
                    basis_q.push_back(triangle_basis(held[0], held[1], in));
                    corner = 0;
                end
            end
            if (out_valid && out_ready)
            begin
                if (basis_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t: unexpected result %p", $realtime, out);
                end
                else
                begin
                    ttb_pkg::basis_t want;
                    want = basis_q.pop_front();
                    if (want.tangent_x !== out.tangent_x || want.tangent_y !== out.tangent_y ||
                        want.tangent_z !== out.tangent_z ||
                        want.bitangent_x !== out.bitangent_x ||
                        want.bitangent_y !== out.bitangent_y ||
                        want.bitangent_z !== out.bitangent_z ||
                        want.degenerate !== out.degenerate)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%t: mismatch\n  expected %p\n  actual   %p",
                                     $realtime, want, out);
                    end
                end
            end
        end
    end
endmodule

FILE: sim/triangle_tangent_bitangent_test.sv
// Testbench top: vertex stimulus, result sink, watchdog and verdict.
module triangle_tangent_bitangent_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TRIANGLES  = 300;
    localparam int LONG_HOLD  = 2000;    // receiver stall long enough to back up the input
    localparam int IDLE_LIMIT = 20000;   // well above one triangle's latency plus a stall

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    ttb_pkg::vertex_t in;
    logic             out_valid;
    logic             out_ready;
    ttb_pkg::basis_t  out;
    int               errors;
    int               pending;

    bit      hold_request;   // asks the sink for one long stall
    bit      no_gaps;        // sender offers back to back
    int      quiet;

    triangle_tangent_bitangent dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in        (in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out       (out)
    );

    triangle_tangent_bitangent_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in        (in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out       (out),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one vertex after a random gap; returns at the falling edge after acceptance.
    task automatic send_vertex(ttb_pkg::vertex_t v);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in       = v;
        // in_ready only moves at rising edges, so its value here holds for the next one
        while (!in_ready) @(negedge clk);
        @(negedge clk);
    endtask

    function automatic ttb_pkg::vertex_t make_vertex(int px, int py, int pz, int u, int v);
        ttb_pkg::vertex_t r;
        r.pos_x = px[15:0];
        r.pos_y = py[15:0];
        r.pos_z = pz[15:0];
        r.tex_u = u[15:0];
        r.tex_v = v[15:0];
        return r;
    endfunction

    function automatic ttb_pkg::vertex_t random_vertex();
        ttb_pkg::vertex_t r;
        r = 80'({$urandom, $urandom, $urandom});
        return r;
    endfunction

    task automatic send_triangle(ttb_pkg::vertex_t a, ttb_pkg::vertex_t b,
                                 ttb_pkg::vertex_t c);
        send_vertex(a);
        send_vertex(b);
        send_vertex(c);
    endtask

    // Random triangle: mostly general, some with degenerate or tiny UV spans, some small and well scaled.
    task automatic random_triangle();
        ttb_pkg::vertex_t a, b, c;
        int               kind;
        a    = random_vertex();
        b    = random_vertex();
        c    = random_vertex();
        kind = $urandom_range(0, 9);
        case (kind)
            6:
            begin
                // repeated UV: zero determinant
                c.tex_u = a.tex_u;
                c.tex_v = a.tex_v;
            end
            7:
            begin
                // collinear UV deltas: zero determinant
                b.tex_u = a.tex_u + 16'($urandom_range(0, 200)) - 16'sd100;
                b.tex_v = a.tex_v + 16'($urandom_range(0, 200)) - 16'sd100;
                c.tex_u = a.tex_u + 16'(2 * (b.tex_u - a.tex_u));
                c.tex_v = a.tex_v + 16'(2 * (b.tex_v - a.tex_v));
            end
            8:
            begin
                // tiny UV spans drive the quotients into saturation
                b.tex_u = a.tex_u + 16'($urandom_range(0, 4)) - 16'sd2;
                b.tex_v = a.tex_v + 16'($urandom_range(0, 4)) - 16'sd2;
                c.tex_u = a.tex_u + 16'($urandom_range(0, 4)) - 16'sd2;
                c.tex_v = a.tex_v + 16'($urandom_range(0, 4)) - 16'sd2;
            end
            9:
            begin
                // small, well-scaled triangle with in-range results
                b = a;
                c = a;
                b.pos_x = a.pos_x + 16'($urandom_range(0, 1023)) - 16'sd512;
                c.pos_y = a.pos_y + 16'($urandom_range(0, 1023)) - 16'sd512;
                b.tex_u = a.tex_u + 16'($urandom_range(1000, 3000));
                c.tex_v = a.tex_v + 16'($urandom_range(1000, 3000));
            end
            default:
            begin
            end
        endcase
        send_triangle(a, b, c);
    endtask

    // Sink: a random stall per result, plus one long stall on request.
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = $urandom_range(0, 6);
            if (hold_request)
            begin
                stall        = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            while (!out_valid) @(negedge clk);
            @(negedge clk);
        end
    end

    // Watchdog: cycles in a row with no item moving on either channel.
    initial
    begin
        quiet = 0;
        forever
        begin
            @(negedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= IDLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in           = '0;
        hold_request = 1'b0;
        no_gaps      = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Unit triangle with unit UVs: tangent along x, bitangent along y.
        send_triangle(make_vertex(0, 0, 0, 0, 0), make_vertex(256, 0, 0, 4096, 0),
                      make_vertex(0, 256, 0, 0, 4096));
        // All UVs equal: degenerate.
        send_triangle(make_vertex(100, -200, 300, 777, -777), make_vertex(-5, 6, -7, 777, -777),
                      make_vertex(9, 9, 9, 777, -777));
        // Field extremes everywhere.
        send_triangle(make_vertex(-32768, -32768, -32768, -32768, -32768),
                      make_vertex(32767, 32767, 32767, 32767, 32767),
                      make_vertex(-32768, 32767, -32768, -32768, 32767));
        // Unit-LSB UV span with maximal edges: positive and negative saturation.
        send_triangle(make_vertex(-32768, 32767, 0, 0, 0), make_vertex(32767, -32768, 1, 1, 0),
                      make_vertex(32767, -32768, -1, 0, 1));
        send_triangle(make_vertex(32767, -32768, 5, 0, 0), make_vertex(-32768, 32767, -5, -1, 0),
                      make_vertex(-32768, 32767, 0, 0, 1));
        // All-zero triangle: degenerate with zero edges.
        send_triangle('0, '0, '0);

        for (int t = 0; t < TRIANGLES; t++)
        begin
            // Back-to-back stretches now and then.
            if (t % 25 == 0)
                no_gaps = ($urandom_range(0, 2) == 0);
            if (t == 100)
                hold_request = 1'b1;
            // Sender pause until the block has drained.
            if (t == 200)
            begin
                in_valid = 1'b0;
                while (pending != 0) @(negedge clk);
            end
            random_triangle();
        end
        in_valid = 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (1000) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_serial_mul.sv
hw/rtl/ttb_serial_div.sv
hw/rtl/triangle_tangent_bitangent.sv
sim/triangle_tangent_bitangent_checker.sv
sim/triangle_tangent_bitangent_test.sv
